// File: rtl/core/tlpp_pkg.sv
// package: constants, engine state type and engine result struct
`timescale 1ns / 1ps
`default_nettype none
package tlpp_pkg;

	localparam int unsigned MAX_LIMIT = 65535;
	localparam int unsigned LIMIT_W   = 16;
	localparam int unsigned MAP_DEPTH = MAX_LIMIT + 1;
	localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH);
	localparam int unsigned PROD_W    = 32;
	localparam int unsigned ROOT_W    = 9;
	localparam int unsigned SQ_W      = 17;
	localparam logic [LIMIT_W-1:0] MIN_LIMIT = LIMIT_W'(3);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SV_RD,
		ST_SV_CHK,
		ST_SV_MARK,
		ST_SC_RD,
		ST_SC_CHK,
		ST_DONE
	} eng_state_t;

	typedef struct packed {
		logic               done;
		logic               too_small;
		logic [LIMIT_W-1:0] p_hi;
		logic [LIMIT_W-1:0] p_lo;
	} eng_res_t;

endpackage
`default_nettype wire

// File: rtl/core/tlpp_req_if.sv
// request channel: limit in
`timescale 1ns / 1ps
`default_nettype none
interface tlpp_req_if;
	logic                         valid;
	logic                         ready;
	logic [tlpp_pkg::LIMIT_W-1:0] limit;

	modport source (output valid, output limit, input ready);
	modport sink (input valid, input limit, output ready);
endinterface
`default_nettype wire

// File: rtl/core/tlpp_rsp_if.sv
// response channel: product and too_small out
`timescale 1ns / 1ps
`default_nettype none
interface tlpp_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tlpp_pkg::PROD_W-1:0] product;
	logic                        too_small;

	modport source (output valid, output product, output too_small, input ready);
	modport sink (input valid, input product, input too_small, output ready);
endinterface
`default_nettype wire

// File: rtl/core/tlpp_sieve.sv
// sieve engine: composite bit map memory, clear, mark and downward scan sequencer
`timescale 1ns / 1ps
`default_nettype none
module tlpp_sieve (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [tlpp_pkg::LIMIT_W-1:0] limit,
	input  wire logic                         ack,
	output      logic                         idle,
	output      tlpp_pkg::eng_res_t           res
);

	tlpp_pkg::eng_state_t state_q, state_d;

	logic [tlpp_pkg::LIMIT_W-1:0] n_q;
	logic [tlpp_pkg::LIMIT_W-1:0] addr_q;
	logic [tlpp_pkg::ROOT_W-1:0]  j_q;
	logic [tlpp_pkg::SQ_W-1:0]    sq_q;
	logic [tlpp_pkg::SQ_W-1:0]    m_q;
	logic [tlpp_pkg::LIMIT_W-1:0] k_q;
	logic                         found_q;
	logic [tlpp_pkg::LIMIT_W-1:0] p_hi_q;
	logic [tlpp_pkg::LIMIT_W-1:0] p_lo_q;
	logic                         small_q;

	logic                         map_we;
	logic                         map_wdata;
	logic [tlpp_pkg::MAP_AW-1:0]  map_addr;
	logic                         map_rdata_q;
	logic                         map_q [tlpp_pkg::MAP_DEPTH];

	logic [tlpp_pkg::SQ_W-1:0]    n_ext;
	logic [tlpp_pkg::SQ_W-1:0]    m_next;
	logic [tlpp_pkg::SQ_W-1:0]    sq_next;
	logic                         sq_over;

	assign n_ext   = {1'b0, n_q};
	assign m_next  = m_q + tlpp_pkg::SQ_W'(j_q);
	// (j+1)^2 = j^2 + 2j + 1
	assign sq_next = sq_q + tlpp_pkg::SQ_W'({j_q, 1'b1});
	assign sq_over = sq_q > n_ext;

	// single port bit map, registered read
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_q[map_addr] <= map_wdata;
		end
		map_rdata_q <= map_q[map_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlpp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tlpp_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (limit < tlpp_pkg::MIN_LIMIT) ? tlpp_pkg::ST_DONE
						: tlpp_pkg::ST_CLEAR;
				end
			end
			tlpp_pkg::ST_CLEAR: begin
				if (addr_q == n_q) begin
					state_d = tlpp_pkg::ST_SV_RD;
				end
			end
			tlpp_pkg::ST_SV_RD: begin
				state_d = sq_over ? tlpp_pkg::ST_SC_RD : tlpp_pkg::ST_SV_CHK;
			end
			tlpp_pkg::ST_SV_CHK: begin
				state_d = map_rdata_q ? tlpp_pkg::ST_SV_RD : tlpp_pkg::ST_SV_MARK;
			end
			tlpp_pkg::ST_SV_MARK: begin
				if (m_next > n_ext) begin
					state_d = tlpp_pkg::ST_SV_RD;
				end
			end
			tlpp_pkg::ST_SC_RD: begin
				state_d = tlpp_pkg::ST_SC_CHK;
			end
			tlpp_pkg::ST_SC_CHK: begin
				state_d = (!map_rdata_q && found_q) ? tlpp_pkg::ST_DONE
					: tlpp_pkg::ST_SC_RD;
			end
			tlpp_pkg::ST_DONE: begin
				if (ack) begin
					state_d = tlpp_pkg::ST_IDLE;
				end
			end
			default: state_d = tlpp_pkg::ST_IDLE;
		endcase
	end

	// memory control and status outputs
	always_comb begin
		map_we        = 1'b0;
		map_wdata     = 1'b0;
		map_addr      = addr_q;
		idle          = 1'b0;
		res.done      = 1'b0;
		res.too_small = small_q;
		res.p_hi      = p_hi_q;
		res.p_lo      = p_lo_q;
		case (state_q)
			tlpp_pkg::ST_IDLE: begin
				idle = 1'b1;
			end
			tlpp_pkg::ST_CLEAR: begin
				map_we = 1'b1;
			end
			tlpp_pkg::ST_SV_RD: begin
				map_addr = tlpp_pkg::MAP_AW'(j_q);
			end
			tlpp_pkg::ST_SV_MARK: begin
				map_we    = 1'b1;
				map_wdata = 1'b1;
				map_addr  = m_q[tlpp_pkg::MAP_AW-1:0];
			end
			tlpp_pkg::ST_SC_RD: begin
				map_addr = k_q;
			end
			tlpp_pkg::ST_DONE: begin
				res.done = 1'b1;
			end
			default: ;
		endcase
	end

	// counters and found primes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			small_q <= 1'b0;
		end else begin
			case (state_q)
				tlpp_pkg::ST_IDLE: begin
					if (start) begin
						found_q <= 1'b0;
						small_q <= limit < tlpp_pkg::MIN_LIMIT;
					end
				end
				tlpp_pkg::ST_SC_CHK: begin
					if (!map_rdata_q) begin
						found_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tlpp_pkg::ST_IDLE: begin
				n_q    <= limit;
				addr_q <= '0;
				j_q    <= tlpp_pkg::ROOT_W'(2);
				sq_q   <= tlpp_pkg::SQ_W'(4);
				p_hi_q <= '0;
				p_lo_q <= '0;
			end
			tlpp_pkg::ST_CLEAR: begin
				addr_q <= addr_q + 1'b1;
			end
			tlpp_pkg::ST_SV_RD: begin
				k_q <= n_q;
				m_q <= sq_q;
			end
			tlpp_pkg::ST_SV_CHK: begin
				if (map_rdata_q) begin
					j_q  <= j_q + 1'b1;
					sq_q <= sq_next;
				end
			end
			tlpp_pkg::ST_SV_MARK: begin
				m_q <= m_next;
				if (m_next > n_ext) begin
					j_q  <= j_q + 1'b1;
					sq_q <= sq_next;
				end
			end
			tlpp_pkg::ST_SC_CHK: begin
				k_q <= k_q - 1'b1;
				if (!map_rdata_q) begin
					if (found_q) begin
						p_lo_q <= k_q;
					end else begin
						p_hi_q <= k_q;
					end
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/two_largest_primes_product_core.sv
// top level: product of the two largest primes not above a limit
`timescale 1ns / 1ps
`default_nettype none
// One limit in, one product out. For a limit of 3 or more the engine clears
// the composite map from address 0 up to the limit, reads the map bit of each
// sieving base up to sqrt(limit) and, if the base is still unmarked, marks its
// multiples from its square up to the limit, then scans down from the limit
// until two primes are found. All of it is paced by the single port of the
// 64K x 1 bit map, which serves one read or one write per cycle. A limit
// below 3 answers with too_small set and product zero. A new limit is taken
// once the engine has handed its result to the output register, while that
// result may still wait on the response channel.
module two_largest_primes_product_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tlpp_req_if.sink    req,
	tlpp_rsp_if.source  rsp
);

	logic                        eng_idle;
	logic                        eng_ack;
	tlpp_pkg::eng_res_t          eng_res;

	logic                        out_valid_q;
	logic [tlpp_pkg::PROD_W-1:0] product_q;
	logic                        too_small_q;

	tlpp_sieve u_sieve (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req.valid && req.ready),
		.limit  (req.limit),
		.ack    (eng_ack),
		.idle   (eng_idle),
		.res    (eng_res)
	);

	assign req.ready = eng_idle;
	assign eng_ack   = eng_res.done && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_ack) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// 16 x 16 multiply straight into the output register
	always_ff @(posedge clk) begin
		if (eng_ack) begin
			too_small_q <= eng_res.too_small;
			product_q   <= eng_res.too_small ? '0
				: tlpp_pkg::PROD_W'(eng_res.p_hi) * tlpp_pkg::PROD_W'(eng_res.p_lo);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.product   = product_q;
	assign rsp.too_small = too_small_q;

	// a transfer in always starts the engine
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !eng_idle)
		else $error("engine idle after accepted limit");

	// a normal result carries two distinct primes, larger first
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		eng_res.done && !eng_res.too_small |-> eng_res.p_hi > eng_res.p_lo)
		else $error("primes out of order");

	// error result has zero product
	a_small_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && too_small_q |-> product_q == '0)
		else $error("nonzero product on too_small");

	// output register is never overwritten while a result waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		eng_ack |-> !out_valid_q || rsp.ready)
		else $error("output overwritten");

endmodule
`default_nettype wire
